// ===== rtl/core/cel_pkg.sv =====
`timescale 1ns / 1ps

package cel_pkg;

   localparam int PROB_W          = 17;
   localparam int WGT_W           = 16;
   localparam int LOSS_W          = 38;
   localparam int SUM_W           = 30;
   localparam int M_W             = 31;
   localparam int FRAC_W          = 16;
   localparam int EXP_W           = 5;
   localparam int NL2_W           = EXP_W + FRAC_W;
   localparam int NLOG_W          = 20;
   localparam int TERM_W          = 21;
   localparam int MUL_W           = 32;
   localparam int PROD_W          = 2 * MUL_W;
   localparam int LOG_ITERS       = 16;
   localparam int ITER_W          = $clog2(LOG_ITERS);
   localparam int CSR_IDX_W       = 1;
   localparam int CSR_DATA_W      = 17;
   localparam int MAX_CLASSES_DEF = 1024;

   localparam logic [PROB_W-1:0] PROB_ONE   = 17'h1_0000;
   localparam logic [SUM_W-1:0]  SUM_MAX    = 30'h3FFF_FFFF;
   localparam logic [MUL_W-1:0]  LN2_Q32    = 32'd2977044472;
   localparam logic [WGT_W-1:0]  WEIGHT_ONE = 16'd256;
   localparam logic [EXP_W-1:0]  EXP_ONE    = 5'd16;

   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT_ENABLE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_PROB_FLOOR    = 1'b1;

   typedef enum logic [1:0] {
      MUL_SQUARE,
      MUL_LN2,
      MUL_TERM,
      MUL_WEIGHT
   } mul_sel_type;

   typedef struct packed {
      mul_sel_type         sel;
      logic [M_W-1:0]      mant;
      logic [NL2_W-1:0]    nl2;
      logic [PROB_W-1:0]   target;
      logic [NLOG_W-1:0]   nlog;
      logic [SUM_W-1:0]    sum;
      logic [WGT_W-1:0]    weight;
   } mul_ops_type;

endpackage

// ===== rtl/core/cel_mul.sv =====
`timescale 1ns / 1ps

module cel_mul (
   input  cel_pkg::mul_ops_type           ops,
   output logic [cel_pkg::PROD_W-1:0]     prod
);
   import cel_pkg::*;

   logic [MUL_W-1:0] op_a;
   logic [MUL_W-1:0] op_b;

   // operand steering for the one shared 32x32 multiplier
   always_comb begin
      unique case (ops.sel)
         MUL_SQUARE: begin
            op_a = MUL_W'(ops.mant);
            op_b = MUL_W'(ops.mant);
         end
         MUL_LN2: begin
            op_a = MUL_W'(ops.nl2);
            op_b = LN2_Q32;
         end
         MUL_TERM: begin
            op_a = MUL_W'(ops.target);
            op_b = MUL_W'(ops.nlog);
         end
         MUL_WEIGHT: begin
            op_a = MUL_W'(ops.sum);
            op_b = MUL_W'(ops.weight);
         end
      endcase
   end

   assign prod = PROD_W'(op_a) * PROD_W'(op_b);

endmodule

// ===== rtl/core/cross_entropy_loss_forward.sv =====
`timescale 1ns / 1ps
// a class beat is taken in idle, then runs through normalise, the 16 squaring
// steps of the log unit on the shared multiplier, ln, term and accumulate
// before req_ready is high again; after the last class beat the weight state
// puts out the loss beat once the output register is free, and req_ready returns
// the loss beat waits in the output register while the next sample's beats come in
// reset (synchronous, active high) clears state, sum, class count, flag and valid

module cross_entropy_loss_forward #(
   parameter int MAX_CLASSES = cel_pkg::MAX_CLASSES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [cel_pkg::PROB_W-1:0]       req_prob,
   input  logic [cel_pkg::PROB_W-1:0]       req_target,
   input  logic [cel_pkg::WGT_W-1:0]        req_sample_weight,
   input  logic                             req_last_class,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [cel_pkg::LOSS_W-1:0]       rsp_loss,
   output logic                             rsp_overflow,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [cel_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [cel_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import cel_pkg::*;

   localparam int CNT_W = $clog2(MAX_CLASSES + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_NORM,
      S_ITER,
      S_LN,
      S_TERM,
      S_ACC,
      S_WEIGHT
   } state_type;

   state_type            state_ff, state_in;
   logic [ITER_W-1:0]    iter_ff, iter_in;
   logic [PROB_W-1:0]    p_ff, p_in;
   logic [PROB_W-1:0]    t_ff, t_in;
   logic [WGT_W-1:0]     sw_ff, sw_in;
   logic                 last_ff, last_in;
   logic [EXP_W-1:0]     exp_ff, exp_in;
   logic [M_W-1:0]       mant_ff, mant_in;
   logic [FRAC_W-1:0]    frac_ff, frac_in;
   logic [NLOG_W-1:0]    nlog_ff, nlog_in;
   logic [TERM_W-1:0]    term_ff, term_in;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 sat_ff, sat_in;
   logic                 weight_enable_ff, weight_enable_in;
   logic [PROB_W-1:0]    prob_floor_ff, prob_floor_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [LOSS_W-1:0]    rsp_loss_ff, rsp_loss_in;
   logic                 rsp_overflow_ff, rsp_overflow_in;

   mul_ops_type          mul_ops;
   logic [PROD_W-1:0]    prod;
   logic [PROD_W-1:0]    prod_rnd;
   logic [MUL_W-1:0]     sq;
   logic [PROB_W-1:0]    floor_eff;
   logic [PROB_W-1:0]    p_clamp;
   logic [EXP_W-1:0]     exp_val;
   logic [NL2_W-1:0]     nl2;
   logic [SUM_W:0]       sum_ext;
   logic                 slot_free;

   function automatic logic [PROB_W-1:0] clamp_one(input logic [PROB_W-1:0] v);
      return (v > PROB_ONE) ? PROB_ONE : v;
   endfunction

   cel_mul u_mul (
      .ops  (mul_ops),
      .prod (prod)
   );

   always_comb begin
      mul_ops.mant   = mant_ff;
      mul_ops.nl2    = nl2;
      mul_ops.target = t_ff;
      mul_ops.nlog   = nlog_ff;
      mul_ops.sum    = sum_ff;
      mul_ops.weight = weight_enable_ff ? sw_ff : WEIGHT_ONE;
      unique case (state_ff)
         S_LN:     mul_ops.sel = MUL_LN2;
         S_TERM:   mul_ops.sel = MUL_TERM;
         S_WEIGHT: mul_ops.sel = MUL_WEIGHT;
         default:  mul_ops.sel = MUL_SQUARE;
      endcase
   end

   always_comb begin
      floor_eff = clamp_one(prob_floor_ff);
      if (floor_eff == '0) begin
         floor_eff = PROB_W'(1);
      end
      p_clamp = clamp_one(req_prob);

      // msb index of the floored probability
      exp_val = '0;
      for (int i = 0; i < PROB_W; i++) begin
         if (p_ff[i]) begin
            exp_val = EXP_W'(i);
         end
      end

      sq        = prod[2*M_W-1:M_W-1];
      nl2       = {EXP_ONE - exp_ff, {FRAC_W{1'b0}}} - NL2_W'(frac_ff);
      sum_ext   = {1'b0, sum_ff} + (SUM_W+1)'(term_ff);
      slot_free = !rsp_valid_ff || rsp_ready;

      unique case (state_ff)
         S_LN:    prod_rnd = prod + (PROD_W'(1) << 31);
         S_TERM:  prod_rnd = prod + (PROD_W'(1) << 15);
         default: prod_rnd = prod + (PROD_W'(1) << 7);
      endcase
   end

   always_comb begin
      state_in         = state_ff;
      iter_in          = iter_ff;
      p_in             = p_ff;
      t_in             = t_ff;
      sw_in            = sw_ff;
      last_in          = last_ff;
      exp_in           = exp_ff;
      mant_in          = mant_ff;
      frac_in          = frac_ff;
      nlog_in          = nlog_ff;
      term_in          = term_ff;
      sum_in           = sum_ff;
      count_in         = count_ff;
      sat_in           = sat_ff;
      weight_enable_in = weight_enable_ff;
      prob_floor_in    = prob_floor_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_loss_in      = rsp_loss_ff;
      rsp_overflow_in  = rsp_overflow_ff;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_WEIGHT_ENABLE: weight_enable_in = csr_wdata[0];
            CSR_PROB_FLOOR:    prob_floor_in    = csr_wdata;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               p_in     = (p_clamp < floor_eff) ? floor_eff : p_clamp;
               t_in     = clamp_one(req_target);
               sw_in    = req_sample_weight;
               last_in  = req_last_class;
               state_in = S_NORM;
            end
         end
         S_NORM: begin
            exp_in   = exp_val;
            mant_in  = M_W'(p_ff) << (EXP_W'(M_W - 1) - exp_val);
            frac_in  = '0;
            iter_in  = '0;
            state_in = S_ITER;
         end
         S_ITER: begin
            // square, and renormalise when the mantissa reaches two
            if (sq[M_W]) begin
               mant_in = sq[M_W:1];
               frac_in = {frac_ff[FRAC_W-2:0], 1'b1};
            end else begin
               mant_in = sq[M_W-1:0];
               frac_in = {frac_ff[FRAC_W-2:0], 1'b0};
            end
            iter_in = iter_ff + ITER_W'(1);
            if (iter_ff == ITER_W'(LOG_ITERS - 1)) begin
               state_in = S_LN;
            end
         end
         S_LN: begin
            nlog_in  = prod_rnd[32+NLOG_W-1:32];
            state_in = S_TERM;
         end
         S_TERM: begin
            term_in  = prod_rnd[16+TERM_W-1:16];
            state_in = S_ACC;
         end
         S_ACC: begin
            if (count_ff < CNT_W'(MAX_CLASSES)) begin
               count_in = count_ff + CNT_W'(1);
               if (sum_ext > {1'b0, SUM_MAX}) begin
                  sum_in = SUM_MAX;
                  sat_in = 1'b1;
               end else begin
                  sum_in = sum_ext[SUM_W-1:0];
               end
            end else begin
               sat_in = 1'b1;
            end
            state_in = last_ff ? S_WEIGHT : S_IDLE;
         end
         S_WEIGHT: begin
            // hold until the output register is free
            if (slot_free) begin
               rsp_valid_in    = 1'b1;
               rsp_loss_in     = prod_rnd[8+LOSS_W-1:8];
               rsp_overflow_in = sat_ff;
               sum_in          = '0;
               count_in        = '0;
               sat_in          = 1'b0;
               state_in        = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      iter_ff         <= iter_in;
      p_ff            <= p_in;
      t_ff            <= t_in;
      sw_ff           <= sw_in;
      last_ff         <= last_in;
      exp_ff          <= exp_in;
      mant_ff         <= mant_in;
      frac_ff         <= frac_in;
      nlog_ff         <= nlog_in;
      term_ff         <= term_in;
      rsp_loss_ff     <= rsp_loss_in;
      rsp_overflow_ff <= rsp_overflow_in;
      if (reset) begin
         state_ff         <= S_IDLE;
         sum_ff           <= '0;
         count_ff         <= '0;
         sat_ff           <= 1'b0;
         weight_enable_ff <= 1'b0;
         prob_floor_ff    <= PROB_W'(1);
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         sum_ff           <= sum_in;
         count_ff         <= count_in;
         sat_ff           <= sat_in;
         weight_enable_ff <= weight_enable_in;
         prob_floor_ff    <= prob_floor_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   assign req_ready    = (state_ff == S_IDLE);
   assign csr_ready    = 1'b1;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_loss     = rsp_loss_ff;
   assign rsp_overflow = rsp_overflow_ff;

endmodule

// ===== rtl/core/cel_checker.sv =====
`timescale 1ns / 1ps

module cel_props (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [cel_pkg::LOSS_W-1:0]   rsp_loss,
   input logic                         rsp_overflow
);
   import cel_pkg::*;

   // a stalled loss beat stays up
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("loss beat dropped while stalled");

   // and keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_loss) && $stable(rsp_overflow))
      else $error("loss beat payload changed while stalled");

   // the log unit is busy right after a class beat is taken
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("class beat taken while log unit busy");

   // no loss beat can come out of a class beat this soon
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("loss beat too early after class beat");

endmodule

bind cross_entropy_loss_forward cel_props u_cel_props (.*);
